// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the capsule overlap test block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_AT(lbl, clk, rst, !(expr), msg)

`endif

// File: rtl/ccot_pkg.sv
// Shared constants and types of the capsule overlap test block.
package ccot_pkg;

   // Number formats.
   localparam int COORD_WIDTH     = 32;
   localparam int FRAC_BITS       = 16;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int RAD_WIDTH       = COORD_WIDTH - 1;
   localparam int PARAM_WIDTH     = PARAM_FRAC_BITS + 1;
   localparam int THR_WIDTH       = 32;
   localparam int DIST_WIDTH      = 64;

   // Datapath widths: dot products, multiplier result and wide accumulators.
   localparam int DW = 2 * (COORD_WIDTH + 1) + 2;
   localparam int WW = 2 * DW + 4;

   // Multiplier digit size and digit index width.
   localparam int MUL_DIGIT  = 17;
   localparam int MUL_DIGITS = (DW + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int MUL_IDX_W  = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;

   // Divider step counter width.
   localparam int DIV_CNT_W = $clog2(PARAM_FRAC_BITS);

   // Stream word widths.
   localparam int REQ_DATA_W = ((6 * COORD_WIDTH + RAD_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS   = 1 + DIST_WIDTH + 2 * PARAM_WIDTH;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Commands carried in the request tuser bit.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(42950);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COORD_WIDTH:0]   diff_type;
   typedef logic signed [DW-1:0]          dot_type;
   typedef logic [2*DW-1:0]               prod_type;
   typedef logic signed [WW-1:0]          wide_type;
   typedef logic [PARAM_WIDTH-1:0]        param_type;
   typedef logic [RAD_WIDTH-1:0]          rad_type;

   localparam param_type PARAM_ONE = param_type'(1) << PARAM_FRAC_BITS;

endpackage

// File: rtl/ccot_mul.sv
// Digit-serial signed multiplier shared by every product of the block.
module ccot_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ccot_pkg::dot_type  op_a,
   input  ccot_pkg::dot_type  op_b,
   output logic               done,
   output ccot_pkg::prod_type prod,
   output logic               prod_neg
);
   import ccot_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   neg_ff, neg_in;
   logic [DW-1:0]          mx_ff, mx_in;
   logic [DW-1:0]          y_ff, y_in;
   logic [MUL_IDX_W-1:0]   i_ff, i_in;
   prod_type               acc_ff, acc_in;
   logic [DW+MUL_DIGIT-1:0] part;
   prod_type               part_w;

   // One digit of the multiplier magnitude per cycle, low digit first.
   always_comb begin
      part   = mx_ff * y_ff[MUL_DIGIT-1:0];
      part_w = prod_type'(part) << (MUL_DIGIT * i_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mx_in   = mx_ff;
      y_in    = y_ff;
      i_in    = i_ff;
      acc_in  = acc_ff;
      if (start) begin
         mx_in   = op_a[DW-1] ? DW'(0 - op_a) : op_a;
         y_in    = op_b[DW-1] ? DW'(0 - op_b) : op_b;
         neg_in  = op_a[DW-1] ^ op_b[DW-1];
         acc_in  = '0;
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part_w;
         y_in   = y_ff >> MUL_DIGIT;
         i_in   = i_ff + 1'b1;
         if ((y_ff >> MUL_DIGIT) == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operands and partial sum.
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mx_ff  <= mx_in;
      y_ff   <= y_in;
      i_ff   <= i_in;
      acc_ff <= acc_in;
   end

   assign done     = done_ff;
   assign prod     = acc_ff;
   assign prod_neg = neg_ff;

endmodule

// File: rtl/ccot_div.sv
// Restoring divider giving a clamped Q1.16 quotient, one bit per cycle.
module ccot_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  ccot_pkg::wide_type  num,
   input  ccot_pkg::wide_type  den,
   output logic                done,
   output ccot_pkg::param_type quot
);
   import ccot_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   wide_type             r_ff, r_in;
   wide_type             den_ff, den_in;
   param_type            q_ff, q_in;
   logic [DIV_CNT_W-1:0] n_ff, n_in;
   wide_type             r2;
   logic                 ge;

   // Quotients at or beyond the ends finish at once; others take one bit a cycle.
   always_comb begin
      r2      = r_ff <<< 1;
      ge      = (r2 >= den_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      r_in    = r_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      n_in    = n_ff;
      if (start) begin
         if (num <= 0) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (num >= den) begin
            q_in    = PARAM_ONE;
            done_in = 1'b1;
         end else begin
            r_in    = num;
            den_in  = den;
            q_in    = '0;
            n_in    = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         r_in = ge ? r2 - den_ff : r2;
         q_in = {q_ff[PARAM_WIDTH-2:0], ge};
         n_in = n_ff + 1'b1;
         if (n_ff == DIV_CNT_W'(PARAM_FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Remainder, divisor and quotient.
   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      n_ff   <= n_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// File: rtl/capsule_capsule_overlap_test_core.sv
// Top level of the capsule overlap test block: sequencer, registers and result stage.
//
// Each request word carries one capsule (start and end in Q16.16, radius in UQ15.16).
// A word with tuser low loads the reference capsule and gives no response. A word
// with tuser high tests its capsule against the reference and gives one response
// word: hit flag, squared closest distance (Q32.32, saturating) and both segment
// parameters (Q1.16). The csr channel writes the near-zero threshold; it is always
// ready. The user is to write it only while the block is idle; the block itself
// does not enforce this. A load leaves the block idle. A test runs on one shared
// 68x17-bit multiplier and one one-bit-per-cycle divider: fifteen products for the
// five dot products, then the divisions and the remaining products.
// req_tready is low for the whole test. The finished result sits in an output
// register; a stalled receiver holds back the next test's result and new requests.
// Reset clears the reference capsule to a point at the origin with radius zero and
// sets the threshold to 42950.
`include "assert_macros.svh"

module capsule_capsule_overlap_test_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, radius, zero fill
   input  logic [ccot_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit, distance_sq, param_ref, param_test, zero fill
   output logic [ccot_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccot_pkg::THR_WIDTH-1:0]    csr_data
);
   import ccot_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DOT   = 4'd1;
   localparam logic [3:0] ST_CLASS = 4'd2;
   localparam logic [3:0] ST_DEN   = 4'd3;
   localparam logic [3:0] ST_DCHK  = 4'd4;
   localparam logic [3:0] ST_TN    = 4'd5;
   localparam logic [3:0] ST_TCHK  = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_DIST  = 4'd8;
   localparam logic [3:0] ST_RSQ   = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   localparam logic DST_S = 1'b0;
   localparam logic DST_T = 1'b1;

   // Sequencer state.
   logic [3:0] state_ff, state_in;
   logic [2:0] j_ff, j_in;
   logic [1:0] k_ff, k_in;
   logic       wait_ff, wait_in;

   // Stored capsule, working vectors and intermediate values.
   coord_type ref_st_ff [3];
   coord_type ref_st_in [3];
   coord_type ref_en_ff [3];
   coord_type ref_en_in [3];
   rad_type   ref_rad_ff, ref_rad_in;
   rad_type   rad_ff, rad_in;
   diff_type  u_ff [3];
   diff_type  u_in [3];
   diff_type  v_ff [3];
   diff_type  v_in [3];
   diff_type  w_ff [3];
   diff_type  w_in [3];
   dot_type   a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   wide_type  wa_ff, wa_in, wb_ff, wb_in, dist_ff, dist_in;
   logic [DIST_WIDTH-1:0] rsq_ff, rsq_in;
   param_type s_ff, s_in, t_ff, t_in;
   logic [THR_WIDTH-1:0]  thr_ff, thr_in;
   wide_type  div_num_ff, div_num_in, div_den_ff, div_den_in;
   logic      div_dst_ff, div_dst_in;
   logic [3:0] div_ret_ff, div_ret_in;

   // Result stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [DIST_WIDTH-1:0] rsp_dsq_ff, rsp_dsq_in;
   param_type             rsp_s_ff, rsp_s_in, rsp_t_ff, rsp_t_in;

   // Request fields.
   coord_type in_st [3];
   coord_type in_en [3];
   rad_type   in_rad;
   logic      req_fire;

   // Shared units.
   logic      mul_go, mul_done, mul_neg;
   dot_type   mul_a, mul_b;
   prod_type  mul_prod;
   logic      div_go, div_done;
   param_type div_q;

   // Accumulate path and decisions.
   wide_type  prod_w, acc_base, acc_sum;
   logic      acc_sub;
   logic      a_zero, c_zero, den_zero, tn_neg, tn_big;
   wide_type  cs_w, neg_d, b_minus_d;
   logic [RAD_WIDTH:0] rsum;
   logic      out_hit, out_sat;
   logic      slot_free;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         in_st[k] = req_tdata[k*COORD_WIDTH +: COORD_WIDTH];
         in_en[k] = req_tdata[(3+k)*COORD_WIDTH +: COORD_WIDTH];
      end
      in_rad = req_tdata[6*COORD_WIDTH +: RAD_WIDTH];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign mul_go = !wait_ff && (state_ff == ST_DOT || state_ff == ST_DEN ||
                   state_ff == ST_TN || state_ff == ST_DIST || state_ff == ST_RSQ);
   assign div_go = !wait_ff && (state_ff == ST_DIV);

   assign rsum = {1'b0, ref_rad_ff} + {1'b0, rad_ff};

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DOT: begin
            case (j_ff)
               3'd0: begin mul_a = dot_type'(u_ff[k_ff]); mul_b = dot_type'(u_ff[k_ff]); end
               3'd1: begin mul_a = dot_type'(u_ff[k_ff]); mul_b = dot_type'(v_ff[k_ff]); end
               3'd2: begin mul_a = dot_type'(v_ff[k_ff]); mul_b = dot_type'(v_ff[k_ff]); end
               3'd3: begin mul_a = dot_type'(u_ff[k_ff]); mul_b = dot_type'(w_ff[k_ff]); end
               default: begin mul_a = dot_type'(v_ff[k_ff]); mul_b = dot_type'(w_ff[k_ff]); end
            endcase
         end
         ST_DEN: begin
            case (j_ff)
               3'd0: begin mul_a = a_ff; mul_b = c_ff; end
               3'd1: begin mul_a = b_ff; mul_b = b_ff; end
               3'd2: begin mul_a = b_ff; mul_b = e_ff; end
               default: begin mul_a = c_ff; mul_b = d_ff; end
            endcase
         end
         ST_TN: begin
            mul_a = b_ff;
            mul_b = {{(DW-PARAM_WIDTH){1'b0}}, s_ff};
         end
         ST_DIST: begin
            case (j_ff)
               3'd0: begin
                  mul_a = dot_type'(u_ff[k_ff]);
                  mul_b = {{(DW-PARAM_WIDTH){1'b0}}, s_ff};
               end
               3'd1: begin
                  mul_a = dot_type'(v_ff[k_ff]);
                  mul_b = {{(DW-PARAM_WIDTH){1'b0}}, t_ff};
               end
               default: begin mul_a = wa_ff[DW-1:0]; mul_b = wa_ff[DW-1:0]; end
            endcase
         end
         ST_RSQ: begin
            mul_a = {{(DW-RAD_WIDTH-1){1'b0}}, rsum};
            mul_b = {{(DW-RAD_WIDTH-1){1'b0}}, rsum};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   ccot_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_go),
      .op_a     (mul_a),
      .op_b     (mul_b),
      .done     (mul_done),
      .prod     (mul_prod),
      .prod_neg (mul_neg)
   );

   ccot_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // Base value and direction for folding a finished product into its register.
   always_comb begin
      prod_w   = {{(WW-2*DW){1'b0}}, mul_prod};
      acc_base = '0;
      acc_sub  = mul_neg;
      case (state_ff)
         ST_DOT: begin
            case (j_ff)
               3'd0:    acc_base = wide_type'(a_ff);
               3'd1:    acc_base = wide_type'(b_ff);
               3'd2:    acc_base = wide_type'(c_ff);
               3'd3:    acc_base = wide_type'(d_ff);
               default: acc_base = wide_type'(e_ff);
            endcase
         end
         ST_DEN: begin
            case (j_ff)
               3'd1: begin acc_base = wa_ff; acc_sub = !mul_neg; end
               3'd3: begin acc_base = wb_ff; acc_sub = !mul_neg; end
               default: acc_base = '0;
            endcase
         end
         ST_TN: acc_base = wide_type'(e_ff) <<< PARAM_FRAC_BITS;
         ST_DIST: begin
            case (j_ff)
               3'd0:    acc_base = wide_type'(w_ff[k_ff]) <<< PARAM_FRAC_BITS;
               3'd1: begin acc_base = wa_ff; acc_sub = !mul_neg; end
               default: acc_base = dist_ff;
            endcase
         end
         default: acc_base = '0;
      endcase
      acc_sum = acc_sub ? acc_base - prod_w : acc_base + prod_w;
   end

   // Near-zero tests, clamping compares and result formatting.
   always_comb begin
      a_zero    = (a_ff < dot_type'({1'b0, thr_ff})) || (a_ff <= 0);
      c_zero    = (c_ff < dot_type'({1'b0, thr_ff})) || (c_ff <= 0);
      den_zero  = (wa_ff < (wide_type'({1'b0, thr_ff}) <<< (2*FRAC_BITS))) || (wa_ff <= 0);
      cs_w      = wide_type'(c_ff) <<< PARAM_FRAC_BITS;
      tn_neg    = (wa_ff < 0);
      tn_big    = (wa_ff > cs_w);
      neg_d     = 0 - wide_type'(d_ff);
      b_minus_d = wide_type'(b_ff) - wide_type'(d_ff);
      out_hit   = (dist_ff <= (wide_type'({1'b0, rsq_ff}) <<< (2*PARAM_FRAC_BITS)));
      out_sat   = |dist_ff[WW-1:2*PARAM_FRAC_BITS+DIST_WIDTH];
      slot_free = !rsp_valid_ff || rsp_tready;
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      wait_in    = wait_ff;
      ref_st_in  = ref_st_ff;
      ref_en_in  = ref_en_ff;
      ref_rad_in = ref_rad_ff;
      rad_in     = rad_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      w_in       = w_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      e_in       = e_ff;
      wa_in      = wa_ff;
      wb_in      = wb_ff;
      dist_in    = dist_ff;
      rsq_in     = rsq_ff;
      s_in       = s_ff;
      t_in       = t_ff;
      thr_in     = thr_ff;
      div_num_in = div_num_ff;
      div_den_in = div_den_ff;
      div_dst_in = div_dst_ff;
      div_ret_in = div_ret_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_dsq_in   = rsp_dsq_ff;
      rsp_s_in     = rsp_s_ff;
      rsp_t_in     = rsp_t_ff;

      if (csr_valid) begin
         thr_in = csr_data;
      end
      if (mul_go || div_go) begin
         wait_in = 1'b1;
      end
      if (mul_done || div_done) begin
         wait_in = 1'b0;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_LOAD) begin
                  ref_st_in  = in_st;
                  ref_en_in  = in_en;
                  ref_rad_in = in_rad;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     u_in[k] = diff_type'(ref_en_ff[k]) - diff_type'(ref_st_ff[k]);
                     v_in[k] = diff_type'(in_en[k]) - diff_type'(in_st[k]);
                     w_in[k] = diff_type'(ref_st_ff[k]) - diff_type'(in_st[k]);
                  end
                  rad_in   = in_rad;
                  a_in     = '0;
                  b_in     = '0;
                  c_in     = '0;
                  d_in     = '0;
                  e_in     = '0;
                  dist_in  = '0;
                  j_in     = '0;
                  k_in     = '0;
                  state_in = ST_DOT;
               end
            end
         end
         ST_DOT: begin
            if (mul_done) begin
               case (j_ff)
                  3'd0:    a_in = acc_sum[DW-1:0];
                  3'd1:    b_in = acc_sum[DW-1:0];
                  3'd2:    c_in = acc_sum[DW-1:0];
                  3'd3:    d_in = acc_sum[DW-1:0];
                  default: e_in = acc_sum[DW-1:0];
               endcase
               if (k_ff == 2'd2) begin
                  k_in = '0;
                  if (j_ff == 3'd4) begin
                     j_in     = '0;
                     state_in = ST_CLASS;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_CLASS: begin
            // Point-like segments take an endpoint; otherwise solve the 2x2 system.
            if (a_zero && c_zero) begin
               s_in     = '0;
               t_in     = '0;
               state_in = ST_DIST;
            end else if (a_zero) begin
               s_in       = '0;
               div_num_in = wide_type'(e_ff);
               div_den_in = wide_type'(c_ff);
               div_dst_in = DST_T;
               div_ret_in = ST_DIST;
               state_in   = ST_DIV;
            end else if (c_zero) begin
               t_in       = '0;
               div_num_in = neg_d;
               div_den_in = wide_type'(a_ff);
               div_dst_in = DST_S;
               div_ret_in = ST_DIST;
               state_in   = ST_DIV;
            end else begin
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            if (mul_done) begin
               if (j_ff < 3'd2) begin
                  wa_in = acc_sum;
               end else begin
                  wb_in = acc_sum;
               end
               if (j_ff == 3'd3) begin
                  j_in     = '0;
                  state_in = ST_DCHK;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_DCHK: begin
            // Nearly parallel segments start from the reference start point.
            if (den_zero) begin
               s_in     = '0;
               state_in = ST_TN;
            end else begin
               div_num_in = wb_ff;
               div_den_in = wa_ff;
               div_dst_in = DST_S;
               div_ret_in = ST_TN;
               state_in   = ST_DIV;
            end
         end
         ST_TN: begin
            if (mul_done) begin
               wa_in    = acc_sum;
               state_in = ST_TCHK;
            end
         end
         ST_TCHK: begin
            // Clamp t to the tested segment and refit s for the chosen end, or divide to get t inside it.
            div_ret_in = ST_DIST;
            state_in   = ST_DIV;
            if (tn_neg) begin
               t_in       = '0;
               div_num_in = neg_d;
               div_den_in = wide_type'(a_ff);
               div_dst_in = DST_S;
            end else if (tn_big) begin
               t_in       = PARAM_ONE;
               div_num_in = b_minus_d;
               div_den_in = wide_type'(a_ff);
               div_dst_in = DST_S;
            end else begin
               div_num_in = wa_ff;
               div_den_in = cs_w;
               div_dst_in = DST_T;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_dst_ff == DST_S) begin
                  s_in = div_q;
               end else begin
                  t_in = div_q;
               end
               state_in = div_ret_ff;
            end
         end
         ST_DIST: begin
            // Per axis: dx = (w << 16) + u*s - v*t, then add dx squared.
            if (mul_done) begin
               if (j_ff == 3'd2) begin
                  dist_in = acc_sum;
                  j_in    = '0;
                  if (k_ff == 2'd2) begin
                     k_in     = '0;
                     state_in = ST_RSQ;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end else begin
                  wa_in = acc_sum;
                  j_in  = j_ff + 1'b1;
               end
            end
         end
         ST_RSQ: begin
            if (mul_done) begin
               rsq_in   = acc_sum[DIST_WIDTH-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = out_hit;
               rsp_dsq_in   = out_sat ? '1 : dist_ff[2*PARAM_FRAC_BITS +: DIST_WIDTH];
               rsp_s_in     = s_ff;
               rsp_t_in     = t_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state and the stored reference capsule.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= '0;
         k_ff         <= '0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
         ref_rad_ff   <= '0;
         for (int k = 0; k < 3; k++) begin
            ref_st_ff[k] <= '0;
            ref_en_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         ref_rad_ff   <= ref_rad_in;
         ref_st_ff    <= ref_st_in;
         ref_en_ff    <= ref_en_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      rad_ff     <= rad_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      w_ff       <= w_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      e_ff       <= e_in;
      wa_ff      <= wa_in;
      wb_ff      <= wb_in;
      dist_ff    <= dist_in;
      rsq_ff     <= rsq_in;
      s_ff       <= s_in;
      t_ff       <= t_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      div_dst_ff <= div_dst_in;
      div_ret_ff <= div_ret_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_dsq_ff <= rsp_dsq_in;
      rsp_s_ff   <= rsp_s_in;
      rsp_t_ff   <= rsp_t_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_BITS){1'b0}}, rsp_t_ff, rsp_s_ff, rsp_dsq_ff,
                        rsp_hit_ff};

   `ASSERT_AT(a_param_range, clock, reset, rsp_valid_ff |-> (rsp_s_ff <= PARAM_ONE && rsp_t_ff <= PARAM_ONE), "segment parameter beyond one")
   `ASSERT_AT(a_test_holds, clock, reset, (req_fire && req_tuser == CMD_TEST) |=> !req_tready, "test word did not start a computation")
   `ASSERT_NEVER(a_wait_state, clock, reset, wait_ff && (state_ff == ST_IDLE || state_ff == ST_OUT), "unit wait outside a compute state")

endmodule
